// ----- design/okvl_pkg.sv -----
package okvl_pkg;

    localparam int ENTRIES    = 16;
    localparam int DATA_BYTES = 8;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 16;
    localparam int DATA_W  = 64;
    localparam int STAT_W  = 3;
    localparam int ENTRY_W = KEY_W + DATA_W;

    // 11-byte words on both sides
    localparam int IN_W  = ((MODE_W + KEY_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_W = ((STAT_W + KEY_W + DATA_W + CNT_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] DATA_MASK = {DATA_W{1'b1}} >> (DATA_W - 8 * DATA_BYTES);
    localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(ENTRIES);

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PREV   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_EDGE     = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } res_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } ram_req_t;

endpackage

// ----- design/ordered_key_value_list_core.sv -----
// Sequence (accept to m_tvalid): full/empty/illegal-mode requests and an insert into an empty
//   list go straight to DONE; other requests scan the list from position 0 to the key or to
//   the end, prev/next then fetch the neighbour (FETCH, FETCH_RD) unless the key is at the edge,
//   and a remove shifts the later entries down one place (SHIFT) before DONE.
// Throughput: one word at a time; the next word is taken the cycle after the result moves to
//   the output register. Reset: rst_n (async, active low) empties the list and the output register; RAM is not cleared.
module ordered_key_value_list_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // slave side: {pad, data_in[63:0], key[15:0], mode[2:0]}, mode at bit 0
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [okvl_pkg::IN_W-1:0]   s_tdata,
    // master side: {entry_count[4:0], data_out[63:0], key_out[15:0], status[2:0]}, status at bit 0
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [okvl_pkg::OUT_W-1:0]  m_tdata
);

    import okvl_pkg::*;

    req_t               req;
    res_t               res;
    logic               res_valid;
    logic               res_ready;
    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;

    // output holding register; decouples the sequencer from the sink
    logic               out_vld_reg, out_vld_next;
    res_t               out_res_reg, out_res_next;

    assign req.mode = s_tdata[MODE_W-1:0];
    assign req.key  = s_tdata[MODE_W+KEY_W-1:MODE_W];
    assign req.data = s_tdata[MODE_W+KEY_W+DATA_W-1:MODE_W+KEY_W];

    // key search and shift-down both run through this one sequencer + comparator
    okvl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // keys and data share one word per entry
    okvl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_vld_reg || m_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_vld_next = 1'b1;
            out_res_next = res;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'({out_res_reg.count, out_res_reg.data,
                              out_res_reg.key, out_res_reg.status});

endmodule

// ----- design/okvl_ram.sv -----
module okvl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/okvl_ctrl.sv -----
module okvl_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  okvl_pkg::req_t                 req,
    output logic                           res_valid,
    input  logic                           res_ready,
    output okvl_pkg::res_t                 res,
    output okvl_pkg::ram_req_t             ram_req,
    input  logic [okvl_pkg::ENTRY_W-1:0]   ram_rdata
);

    import okvl_pkg::*;

    typedef enum logic [2:0] {IDLE, SCAN, FETCH, FETCH_RD, SHIFT, DONE} state_t;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [KEY_W-1:0]  rkey_reg, rkey_next;
    logic [DATA_W-1:0] rdata_reg, rdata_next;

    logic [KEY_W-1:0]  rd_key;
    logic [DATA_W-1:0] rd_data;
    logic              hit;
    logic [CNT_W-1:0]  dst_idx;

    assign rd_key  = ram_rdata[ENTRY_W-1:DATA_W];
    assign rd_data = ram_rdata[DATA_W-1:0];
    // the single compare unit: key under test against the word just read
    assign hit     = chk_vld_reg && (rd_key == key_reg);
    assign dst_idx = chk_idx_reg - 1'b1;

    assign req_ready  = (state_reg == IDLE);
    assign res_valid  = (state_reg == DONE);
    assign res.status = status_reg;
    assign res.key    = rkey_reg;
    assign res.data   = rdata_reg;
    assign res.count  = count_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        data_next     = data_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        status_next   = status_reg;
        rkey_next     = rkey_reg;
        rdata_next    = rdata_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = count_reg[IDX_W-1:0];
        ram_req.wdata = {key_reg, data_reg};
        ram_req.raddr = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    mode_next    = req.mode;
                    key_next     = req.key;
                    data_next    = req.data & DATA_MASK;
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                    rkey_next    = '0;
                    rdata_next   = '0;
                    status_next  = ST_OK;
                    unique case (req.mode)
                        MODE_INSERT:
                        begin
                            if (count_reg == COUNT_FULL)
                            begin
                                status_next = ST_FULL;
                                state_next  = DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = '0;
                                ram_req.wdata = {req.key, req.data & DATA_MASK};
                                count_next    = count_reg + 1'b1;
                                state_next    = DONE;
                            end
                            else
                            begin
                                state_next = SCAN;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = DONE;
                            end
                            else
                            begin
                                state_next = SCAN;
                            end
                        end
                        MODE_FIND, MODE_PREV, MODE_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                                state_next  = DONE;
                            end
                            else
                            begin
                                state_next = SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOTFOUND;
                            state_next  = DONE;
                        end
                    endcase
                end
            end

            SCAN:
            begin
                if (hit)
                begin
                    unique case (mode_reg)
                        MODE_INSERT:
                        begin
                            status_next = ST_DUP;
                            state_next  = DONE;
                        end
                        MODE_REMOVE:
                        begin
                            idx_next     = chk_idx_reg + 1'b1;
                            chk_vld_next = 1'b0;
                            state_next   = SHIFT;
                        end
                        MODE_FIND:
                        begin
                            rkey_next  = rd_key;
                            rdata_next = rd_data;
                            state_next = DONE;
                        end
                        MODE_PREV:
                        begin
                            if (chk_idx_reg == '0)
                            begin
                                status_next = ST_EDGE;
                                rkey_next   = rd_key;
                                rdata_next  = rd_data;
                                state_next  = DONE;
                            end
                            else
                            begin
                                idx_next   = chk_idx_reg - 1'b1;
                                state_next = FETCH;
                            end
                        end
                        MODE_NEXT:
                        begin
                            if ((chk_idx_reg + 1'b1) == count_reg)
                            begin
                                status_next = ST_EDGE;
                                rkey_next   = rd_key;
                                rdata_next  = rd_data;
                                state_next  = DONE;
                            end
                            else
                            begin
                                idx_next   = chk_idx_reg + 1'b1;
                                state_next = FETCH;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOTFOUND;
                            state_next  = DONE;
                        end
                    endcase
                end
                else if (idx_reg == count_reg)
                begin
                    // last stored entry compared without a match
                    if (mode_reg == MODE_INSERT)
                    begin
                        ram_req.we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    state_next = DONE;
                end
                else
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg;
                    idx_next     = idx_reg + 1'b1;
                end
            end

            FETCH:
            begin
                state_next = FETCH_RD;
            end

            FETCH_RD:
            begin
                rkey_next  = rd_key;
                rdata_next = rd_data;
                state_next = DONE;
            end

            SHIFT:
            begin
                // read at idx, write the word one place lower in the following cycle
                if (chk_vld_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = dst_idx[IDX_W-1:0];
                    ram_req.wdata = ram_rdata;
                end
                if (idx_reg < count_reg)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg;
                    idx_next     = idx_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = DONE;
                    end
                end
            end

            DONE:
            begin
                if (res_ready)
                begin
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        data_reg    <= data_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        status_reg  <= status_next;
        rkey_reg    <= rkey_next;
        rdata_reg   <= rdata_next;
    end

endmodule
